FILE: rtl/gcoc_pkg.sv
// ---------------------------------------------------------------------------
// gcoc_pkg
// Shared types, widths, register indexes and label codes of the grid cell
// occupancy classifier.
// ---------------------------------------------------------------------------
package gcoc_pkg;

    localparam int DEF_GRID_CELLS    = 7;
    localparam int DEF_MAX_IMAGE_DIM = 4096;
    localparam int QUEUE_DEPTH       = 4;

    localparam int PIXEL_BITS     = 8;
    localparam int IMG_BITS       = 13;
    localparam int CELL_BITS      = 10;
    localparam int THR_BITS       = 7;
    localparam int SEL_BITS       = 3;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 3;
    localparam int COUNT_BITS     = 19;
    localparam int PART_BITS      = THR_BITS + CELL_BITS;
    localparam int NEED_BITS      = PART_BITS + CELL_BITS;
    localparam int PROD_BITS      = COUNT_BITS + THR_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [PIXEL_BITS-1:0] WHITE     = 8'hFF;
    localparam int                    PCT_SCALE = 100;

    localparam logic [IMG_BITS-1:0]  RST_IMAGE_WIDTH = 13'd1024;
    localparam logic [CELL_BITS-1:0] RST_CELL_WIDTH  = 10'd146;
    localparam logic [CELL_BITS-1:0] RST_CELL_HEIGHT = 10'd114;
    localparam logic [THR_BITS-1:0]  RST_THRESHOLD   = 7'd5;
    localparam logic [SEL_BITS-1:0]  RST_START_ROW   = 3'd6;
    localparam logic [SEL_BITS-1:0]  RST_START_COL   = 3'd3;
    localparam logic [SEL_BITS-1:0]  RST_GOAL_ROW    = 3'd1;
    localparam logic [SEL_BITS-1:0]  RST_GOAL_COL    = 3'd2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH = 3'd0,
        REG_CELL_WIDTH  = 3'd1,
        REG_CELL_HEIGHT = 3'd2,
        REG_THRESHOLD   = 3'd3,
        REG_START_ROW   = 3'd4,
        REG_START_COL   = 3'd5,
        REG_GOAL_ROW    = 3'd6,
        REG_GOAL_COL    = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        LABEL_START    = 2'd0,
        LABEL_OBSTACLE = 2'd1,
        LABEL_GOAL     = 2'd2,
        LABEL_EMPTY    = 2'd3
    } label_t;

    // Cell sizes are already forced to at least one.
    typedef struct packed {
        logic [IMG_BITS-1:0]  image_width;
        logic [CELL_BITS-1:0] cell_w;
        logic [CELL_BITS-1:0] cell_h;
        logic [SEL_BITS-1:0]  start_row;
        logic [SEL_BITS-1:0]  start_col;
        logic [SEL_BITS-1:0]  goal_row;
        logic [SEL_BITS-1:0]  goal_col;
        logic [NEED_BITS-1:0] need;
    } cfg_t;

endpackage

FILE: rtl/gcoc_cfg.sv
// ---------------------------------------------------------------------------
// gcoc_cfg
// Configuration registers and the precomputed obstacle threshold product.
// ---------------------------------------------------------------------------
module gcoc_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [gcoc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [gcoc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output gcoc_pkg::cfg_t                      cfg
);
    import gcoc_pkg::*;

    logic [IMG_BITS-1:0]  image_width_reg;
    logic [CELL_BITS-1:0] cell_width_reg;
    logic [CELL_BITS-1:0] cell_height_reg;
    logic [THR_BITS-1:0]  threshold_reg;
    logic [SEL_BITS-1:0]  start_row_reg;
    logic [SEL_BITS-1:0]  start_col_reg;
    logic [SEL_BITS-1:0]  goal_row_reg;
    logic [SEL_BITS-1:0]  goal_col_reg;
    logic [PART_BITS-1:0] part_reg;
    logic [PART_BITS-1:0] part_next;
    logic [NEED_BITS-1:0] need_reg;
    logic [NEED_BITS-1:0] need_next;
    logic [CELL_BITS-1:0] cw_eff;
    logic [CELL_BITS-1:0] ch_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= RST_IMAGE_WIDTH;
            cell_width_reg  <= RST_CELL_WIDTH;
            cell_height_reg <= RST_CELL_HEIGHT;
            threshold_reg   <= RST_THRESHOLD;
            start_row_reg   <= RST_START_ROW;
            start_col_reg   <= RST_START_COL;
            goal_row_reg    <= RST_GOAL_ROW;
            goal_col_reg    <= RST_GOAL_COL;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                REG_IMAGE_WIDTH: image_width_reg <= cfg_data[IMG_BITS-1:0];
                REG_CELL_WIDTH:  cell_width_reg  <= cfg_data[CELL_BITS-1:0];
                REG_CELL_HEIGHT: cell_height_reg <= cfg_data[CELL_BITS-1:0];
                REG_THRESHOLD:   threshold_reg   <= cfg_data[THR_BITS-1:0];
                REG_START_ROW:   start_row_reg   <= cfg_data[SEL_BITS-1:0];
                REG_START_COL:   start_col_reg   <= cfg_data[SEL_BITS-1:0];
                REG_GOAL_ROW:    goal_row_reg    <= cfg_data[SEL_BITS-1:0];
                REG_GOAL_COL:    goal_col_reg    <= cfg_data[SEL_BITS-1:0];
                default:         ;
            endcase
        end
    end

    assign cw_eff = (cell_width_reg == '0)  ? CELL_BITS'(1) : cell_width_reg;
    assign ch_eff = (cell_height_reg == '0) ? CELL_BITS'(1) : cell_height_reg;

    // The threshold product is registered through part_reg and then need_reg after
    // a configuration write.
    assign part_next = PART_BITS'(threshold_reg) * PART_BITS'(cw_eff);
    assign need_next = NEED_BITS'(part_reg) * NEED_BITS'(ch_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg <= '0;
            need_reg <= '0;
        end
        else
        begin
            part_reg <= part_next;
            need_reg <= need_next;
        end
    end

    assign cfg.image_width = image_width_reg;
    assign cfg.cell_w      = cw_eff;
    assign cfg.cell_h      = ch_eff;
    assign cfg.start_row   = start_row_reg;
    assign cfg.start_col   = start_col_reg;
    assign cfg.goal_row    = goal_row_reg;
    assign cfg.goal_col    = goal_col_reg;
    assign cfg.need        = need_reg;

endmodule

FILE: rtl/gcoc_front.sv
// ---------------------------------------------------------------------------
// gcoc_front
// Raster position tracking and per-column dark pixel counting; emits one
// queue entry when the last pixel of a cell is accepted.
// ---------------------------------------------------------------------------
module gcoc_front #(
    parameter int GRID_CELLS    = gcoc_pkg::DEF_GRID_CELLS,
    parameter int MAX_IMAGE_DIM = gcoc_pkg::DEF_MAX_IMAGE_DIM,
    parameter int IDX_W         = $clog2(GRID_CELLS)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gcoc_pkg::cfg_t                  cfg,
    input  logic                            accept,
    input  logic [gcoc_pkg::PIXEL_BITS-1:0] pixel,
    input  logic                            frame_start,
    output logic                            push,
    output logic [IDX_W-1:0]                push_row,
    output logic [IDX_W-1:0]                push_col,
    output logic [gcoc_pkg::COUNT_BITS-1:0] push_count,
    output logic                            push_last
);
    import gcoc_pkg::*;

    localparam int POS_W = $clog2(GRID_CELLS + 1);
    localparam int COL_W = $clog2(MAX_IMAGE_DIM);
    localparam int IW_W  = $clog2(MAX_IMAGE_DIM + 1);
    localparam logic [POS_W-1:0] GRID_END = POS_W'(GRID_CELLS);
    localparam logic [POS_W-1:0] GRID_TOP = POS_W'(GRID_CELLS - 1);

    logic                  frame_active_reg;
    logic [COL_W-1:0]      col_pos_reg;
    logic [CELL_BITS-1:0]  off_col_reg;
    logic [POS_W-1:0]      grid_col_reg;
    logic [CELL_BITS-1:0]  off_row_reg;
    logic [POS_W-1:0]      grid_row_reg;
    logic [COUNT_BITS-1:0] counts_reg [GRID_CELLS];

    logic                  active;
    logic [COL_W-1:0]      col_pos_b;
    logic [CELL_BITS-1:0]  off_col_b;
    logic [POS_W-1:0]      grid_col_b;
    logic [CELL_BITS-1:0]  off_row_b;
    logic [POS_W-1:0]      grid_row_b;
    logic                  run;
    logic                  in_col;
    logic [IDX_W-1:0]      col_idx;
    logic [COUNT_BITS-1:0] count_b;
    logic [COUNT_BITS-1:0] count_new;
    logic                  done;
    logic [IW_W-1:0]       iw;
    logic                  row_end;
    logic                  band_end;
    logic                  cell_col_end;

    // A frame start restarts the frame before its own pixel is counted.
    assign active     = frame_start || frame_active_reg;
    assign col_pos_b  = frame_start ? '0 : col_pos_reg;
    assign off_col_b  = frame_start ? '0 : off_col_reg;
    assign grid_col_b = frame_start ? '0 : grid_col_reg;
    assign off_row_b  = frame_start ? '0 : off_row_reg;
    assign grid_row_b = frame_start ? '0 : grid_row_reg;
    assign run        = active && (grid_row_b < GRID_END);
    assign in_col     = grid_col_b < GRID_END;
    assign col_idx    = in_col ? grid_col_b[IDX_W-1:0] : '0;
    assign count_b    = frame_start ? '0 : counts_reg[col_idx];
    assign count_new  = count_b +
                        COUNT_BITS'((pixel != WHITE) && (count_b != COUNT_MAX));

    assign done = run && in_col
               && (off_col_b == cfg.cell_w - CELL_BITS'(1))
               && (off_row_b == cfg.cell_h - CELL_BITS'(1));

    always_comb
    begin
        if (32'(cfg.image_width) > 32'(MAX_IMAGE_DIM))
            iw = IW_W'(MAX_IMAGE_DIM);
        else
            iw = IW_W'(cfg.image_width);
    end

    assign row_end      = (IW_W'(col_pos_b) + IW_W'(1)) >= iw;
    assign band_end     = ({1'b0, off_row_b} + 1'b1) >= {1'b0, cfg.cell_h};
    assign cell_col_end = ({1'b0, off_col_b} + 1'b1) >= {1'b0, cfg.cell_w};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_active_reg <= 1'b0;
            col_pos_reg      <= '0;
            off_col_reg      <= '0;
            grid_col_reg     <= '0;
            off_row_reg      <= '0;
            grid_row_reg     <= '0;
        end
        else if (accept && run)
        begin
            frame_active_reg <= 1'b1;
            if (row_end)
            begin
                col_pos_reg  <= '0;
                off_col_reg  <= '0;
                grid_col_reg <= '0;
                if (band_end)
                begin
                    off_row_reg  <= '0;
                    grid_row_reg <= grid_row_b + POS_W'(1);
                end
                else
                begin
                    off_row_reg  <= off_row_b + CELL_BITS'(1);
                    grid_row_reg <= grid_row_b;
                end
            end
            else
            begin
                col_pos_reg  <= col_pos_b + COL_W'(1);
                off_row_reg  <= off_row_b;
                grid_row_reg <= grid_row_b;
                if (in_col && cell_col_end)
                begin
                    off_col_reg  <= '0;
                    grid_col_reg <= grid_col_b + POS_W'(1);
                end
                else if (in_col)
                begin
                    off_col_reg  <= off_col_b + CELL_BITS'(1);
                    grid_col_reg <= grid_col_b;
                end
                else
                begin
                    off_col_reg  <= off_col_b;
                    grid_col_reg <= grid_col_b;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GRID_CELLS; i++)
                counts_reg[i] <= '0;
        end
        else if (accept && run)
        begin
            for (int i = 0; i < GRID_CELLS; i++)
            begin
                if (in_col && (IDX_W'(i) == col_idx))
                    counts_reg[i] <= done ? '0 : count_new;
                else if (frame_start)
                    counts_reg[i] <= '0;
            end
        end
    end

    assign push       = accept && done;
    assign push_row   = grid_row_b[IDX_W-1:0];
    assign push_col   = col_idx;
    assign push_count = count_new;
    assign push_last  = (grid_row_b == GRID_TOP) && (grid_col_b == GRID_TOP);

endmodule

FILE: rtl/gcoc_queue.sv
// ---------------------------------------------------------------------------
// gcoc_queue
// Short register queue that decouples the counting front from the
// classifying back end.
// ---------------------------------------------------------------------------
module gcoc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = gcoc_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty,
    output logic             full
);
    import gcoc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign empty     = count_reg == '0;
    assign full      = count_reg == CNT_W'(DEPTH);
    assign head_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue fill count lost a beat");

endmodule

FILE: rtl/gcoc_back.sv
// ---------------------------------------------------------------------------
// gcoc_back
// Two stage classifier: scales the dark count, then compares it with the
// threshold product and applies the start and goal overrides.
// ---------------------------------------------------------------------------
module gcoc_back #(
    parameter int IDX_W = $clog2(gcoc_pkg::DEF_GRID_CELLS)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gcoc_pkg::cfg_t                  cfg,
    input  logic                            head_valid,
    input  logic [IDX_W-1:0]                head_row,
    input  logic [IDX_W-1:0]                head_col,
    input  logic [gcoc_pkg::COUNT_BITS-1:0] head_count,
    input  logic                            head_last,
    output logic                            pop,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [IDX_W-1:0]                cell_row,
    output logic [IDX_W-1:0]                cell_col,
    output logic [1:0]                      cell_label,
    output logic [gcoc_pkg::COUNT_BITS-1:0] dark_count,
    output logic                            last_cell
);
    import gcoc_pkg::*;

    logic                  a_valid_reg;
    logic [IDX_W-1:0]      a_row_reg;
    logic [IDX_W-1:0]      a_col_reg;
    logic [COUNT_BITS-1:0] a_count_reg;
    logic                  a_last_reg;
    logic [PROD_BITS-1:0]  a_prod_reg;
    logic [PROD_BITS-1:0]  a_prod_next;

    logic                  b_valid_reg;
    logic [IDX_W-1:0]      b_row_reg;
    logic [IDX_W-1:0]      b_col_reg;
    logic [COUNT_BITS-1:0] b_count_reg;
    logic                  b_last_reg;
    label_t                b_label_reg;
    label_t                b_label_next;

    logic                  b_ready;
    logic                  a_ready;

    assign b_ready = !b_valid_reg || !result_stall;
    assign a_ready = !a_valid_reg || b_ready;
    assign pop     = head_valid && a_ready;

    assign a_prod_next = PROD_BITS'(head_count) * PROD_BITS'(PCT_SCALE);

    always_comb
    begin
        b_label_next = ({1'b0, a_prod_reg} >= cfg.need) ? LABEL_OBSTACLE : LABEL_EMPTY;
        if ((32'(a_row_reg) == 32'(cfg.start_row)) && (32'(a_col_reg) == 32'(cfg.start_col)))
            b_label_next = LABEL_START;
        if ((32'(a_row_reg) == 32'(cfg.goal_row)) && (32'(a_col_reg) == 32'(cfg.goal_col)))
            b_label_next = LABEL_GOAL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= head_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_row_reg   <= head_row;
            a_col_reg   <= head_col;
            a_count_reg <= head_count;
            a_last_reg  <= head_last;
            a_prod_reg  <= a_prod_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_row_reg   <= a_row_reg;
            b_col_reg   <= a_col_reg;
            b_count_reg <= a_count_reg;
            b_last_reg  <= a_last_reg;
            b_label_reg <= b_label_next;
        end
    end

    assign result_valid = b_valid_reg;
    assign cell_row     = b_row_reg;
    assign cell_col     = b_col_reg;
    assign cell_label   = b_label_reg;
    assign dark_count   = b_count_reg;
    assign last_cell    = b_last_reg;

    a_goal_wins: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (32'(cell_row) == 32'(cfg.goal_row))
         && (32'(cell_col) == 32'(cfg.goal_col))) |-> (cell_label == LABEL_GOAL))
        else $error("goal cell not labeled goal");

    a_a_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && b_ready) |=> b_valid_reg)
        else $error("scaled entry dropped before classification");

endmodule

FILE: rtl/grid_cell_occupancy_classifier.sv
// ---------------------------------------------------------------------------
// grid_cell_occupancy_classifier
// Counts non-white pixels per cell of a square grid laid over a raster
// stream and reports one classified cell when its last pixel arrives.
// ---------------------------------------------------------------------------
// Throughput: one pixel beat per cycle while pixel_stall is low.
// Result path: the entry of a cell's last pixel is registered in the queue, then
//   in the count scaling multiplier stage, then in the compare and output register.
// Pixel input stalls only while the four-entry queue is full under output stall.
// Reset: configuration takes its default values, the frame is inactive, all
//   counts are zero and the pipeline is empty; no clearing pass is needed.
module grid_cell_occupancy_classifier #(
    parameter int GRID_CELLS    = gcoc_pkg::DEF_GRID_CELLS,
    parameter int MAX_IMAGE_DIM = gcoc_pkg::DEF_MAX_IMAGE_DIM,
    parameter int IDX_W         = $clog2(GRID_CELLS)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [gcoc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [gcoc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  logic [gcoc_pkg::PIXEL_BITS-1:0]     pixel,
    input  logic                                frame_start,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [IDX_W-1:0]                    cell_row,
    output logic [IDX_W-1:0]                    cell_col,
    output logic [1:0]                          cell_label,
    output logic [gcoc_pkg::COUNT_BITS-1:0]     dark_count,
    output logic                                last_cell
);
    import gcoc_pkg::*;

    localparam int ENTRY_W = 2 * IDX_W + COUNT_BITS + 1;

    cfg_t                  cfg;
    logic                  accept;
    logic                  push;
    logic [IDX_W-1:0]      push_row;
    logic [IDX_W-1:0]      push_col;
    logic [COUNT_BITS-1:0] push_count;
    logic                  push_last;
    logic                  pop;
    logic                  q_empty;
    logic                  q_full;
    logic [ENTRY_W-1:0]    head_data;
    logic [IDX_W-1:0]      head_row;
    logic [IDX_W-1:0]      head_col;
    logic [COUNT_BITS-1:0] head_count;
    logic                  head_last;

    assign pixel_stall = q_full;
    assign accept      = pixel_valid && !pixel_stall;

    gcoc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gcoc_front #(
        .GRID_CELLS    (GRID_CELLS),
        .MAX_IMAGE_DIM (MAX_IMAGE_DIM),
        .IDX_W         (IDX_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .pixel       (pixel),
        .frame_start (frame_start),
        .push        (push),
        .push_row    (push_row),
        .push_col    (push_col),
        .push_count  (push_count),
        .push_last   (push_last)
    );

    gcoc_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_row, push_col, push_count, push_last}),
        .pop       (pop),
        .head_data (head_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign {head_row, head_col, head_count, head_last} = head_data;

    gcoc_back #(
        .IDX_W (IDX_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head_valid   (!q_empty),
        .head_row     (head_row),
        .head_col     (head_col),
        .head_count   (head_count),
        .head_last    (head_last),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cell_row     (cell_row),
        .cell_col     (cell_col),
        .cell_label   (cell_label),
        .dark_count   (dark_count),
        .last_cell    (last_cell)
    );

endmodule
